// ----- design/rss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg
// Shared constants, operation codes and controller/datapath types for the
// Reynolds stress source block.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IN_W           = 32;
  localparam int AREA_W         = 31;
  localparam int RHO_W          = 31;
  localparam int ACC_W          = 64;

  localparam logic [RHO_W-1:0] RHO_RESET = 31'd65536;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_RHO_U  = 4'd0;
  localparam logic [OP_W-1:0] OP_RHO_V  = 4'd1;
  localparam logic [OP_W-1:0] OP_RUU    = 4'd2;
  localparam logic [OP_W-1:0] OP_RVV    = 4'd3;
  localparam logic [OP_W-1:0] OP_RUV    = 4'd4;
  localparam logic [OP_W-1:0] OP_F_XUU  = 4'd5;
  localparam logic [OP_W-1:0] OP_F_YVV  = 4'd6;
  localparam logic [OP_W-1:0] OP_F_XUV  = 4'd7;
  localparam logic [OP_W-1:0] OP_F_YUV  = 4'd8;
  localparam logic [OP_W-1:0] OP_A_XXX  = 4'd9;
  localparam logic [OP_W-1:0] OP_A_YYY  = 4'd10;
  localparam logic [OP_W-1:0] OP_A_XXY  = 4'd11;
  localparam logic [OP_W-1:0] OP_A_YXY  = 4'd12;
  localparam logic [OP_W-1:0] OP_LAST   = OP_A_YXY;

  typedef struct packed {
    logic            load;
    logic            issue;
    logic            wb;
    logic [OP_W-1:0] op;
    logic            div_ld;
    logic            div_step;
    logic            div_fin;
    logic            axis;
    logic            out_load;
  } rss_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } rss_sts_t;

endpackage
`default_nettype wire

// ----- design/rss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss_ctrl
// Sequencer that steps the shared multiplier through the per-node products
// and runs the bit-serial divider twice on the last node of a cell.
// ----------------------------------------------------------------------------
module rss_ctrl
  import rss_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rss_sts_t sts,
  output rss_cmd_t      cmd
);

  localparam int NW    = ACC_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_WB   = 3'd2;
  localparam logic [2:0] S_DLD  = 3'd3;
  localparam logic [2:0] S_DRUN = 3'd4;
  localparam logic [2:0] S_DFIN = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]       state, state_next;
  logic [OP_W-1:0]  op, op_next;
  logic             axis, axis_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_RHO_U;
      axis  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    axis_next  = axis;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = op;
    cmd.axis   = axis;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          op_next    = OP_RHO_U;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.issue  = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (op == OP_LAST) begin
          axis_next  = 1'b0;
          state_next = sts.last ? S_DLD : S_IDLE;
        end else begin
          op_next    = op + 1'b1;
          state_next = S_MUL;
        end
      end
      S_DLD: begin
        cmd.div_ld = 1'b1;
        cnt_next   = '0;
        state_next = S_DRUN;
      end
      S_DRUN: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(NW - 1)) begin
          state_next = S_DFIN;
        end
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_DLD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/rss_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss_dp
// Datapath: node registers, one shared fixed-point multiplier, saturating
// accumulators, a bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module rss_dp
  import rss_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire rss_cmd_t               cmd,
  output rss_sts_t                    sts,
  input  wire logic                   cfg_we,
  input  wire logic [RHO_W-1:0]       cfg_wdata,
  input  wire logic signed [IN_W-1:0] normal_x,
  input  wire logic signed [IN_W-1:0] normal_y,
  input  wire logic signed [IN_W-1:0] inst_u,
  input  wire logic signed [IN_W-1:0] inst_v,
  input  wire logic signed [IN_W-1:0] avg_u,
  input  wire logic signed [IN_W-1:0] avg_v,
  input  wire logic signed [IN_W-1:0] avg_stress_xx,
  input  wire logic signed [IN_W-1:0] avg_stress_xy,
  input  wire logic signed [IN_W-1:0] avg_stress_yy,
  input  wire logic [AREA_W-1:0]      cell_area,
  input  wire logic                   last_node,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [DATA_WIDTH-1:0] source_x,
  output logic signed [DATA_WIDTH-1:0] source_y,
  output logic                        saturated
);

  localparam int DW   = DATA_WIDTH;
  localparam int OW   = (DW > IN_W) ? DW : IN_W;
  localparam int PW   = 2 * OW;
  localparam int NW   = ACC_W + FRAC_BITS;
  localparam int WW   = (PW > NW) ? PW : NW;
  localparam int DFW  = IN_W + 1;
  localparam int CW   = ((DFW > DW) ? DFW : DW) + 1;
  localparam int RMW  = AREA_W + 2;
  localparam logic [WW-1:0] MAXMAG = {{(WW-1){1'b0}}, 1'b1} << (DW - 1);
  localparam logic signed [CW-1:0] PMAX =
    $signed({{(CW-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [CW-1:0] NMIN = -PMAX - CW'(1);

  function automatic logic [DW:0] from_mag(input logic [WW-1:0] m, input logic neg);
    logic [DW-1:0] v;
    logic          c;
    begin
      c = 1'b0;
      if (neg) begin
        if (m > MAXMAG) begin
          c = 1'b1;
          v = MAXMAG[DW-1:0];
        end else begin
          v = -m[DW-1:0];
        end
      end else begin
        if (m > MAXMAG - WW'(1)) begin
          c = 1'b1;
          v = MAXMAG[DW-1:0] - DW'(1);
        end else begin
          v = m[DW-1:0];
        end
      end
      return {c, v};
    end
  endfunction

  function automatic logic signed [OW-1:0] sat_diff(input logic signed [DFW-1:0] d);
    logic signed [CW-1:0] de;
    logic signed [DW-1:0] r;
    begin
      de = CW'(d);
      if (de > PMAX) r = PMAX[DW-1:0];
      else if (de < NMIN) r = NMIN[DW-1:0];
      else r = de[DW-1:0];
      return OW'(r);
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] sadd(input logic signed [ACC_W-1:0] a,
                                                   input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    begin
      s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
      if (s[ACC_W] != s[ACC_W-1])
        return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      return s[ACC_W-1:0];
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] ssub(input logic signed [ACC_W-1:0] a,
                                                   input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    begin
      s = (ACC_W+1)'(a) - (ACC_W+1)'(b);
      if (s[ACC_W] != s[ACC_W-1])
        return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      return s[ACC_W-1:0];
    end
  endfunction

  logic [RHO_W-1:0]          rho;
  logic signed [OW-1:0]      nx, ny, sxx, sxy, syy, pu, pv;
  logic signed [OW-1:0]      m0, m1, ruu, rvv, ruv;
  logic [AREA_W-1:0]         area;
  logic                      last;
  logic [PW-1:0]             prod;
  logic                      psign;
  logic signed [ACC_W-1:0]   fsum [4];
  logic signed [ACC_W-1:0]   asum [4];
  logic [NW-1:0]             num;
  logic [RMW-2:0]            rem;
  logic [RMW-2:0]            dreg;
  logic                      dneg;
  logic signed [DW-1:0]      res_x, res_y;
  logic                      clip_x, clip_y;

  logic signed [OW-1:0]      opa, opb;
  logic [OW-1:0]             ma, mb;
  logic [DW:0]               pres;
  logic signed [ACC_W-1:0]   pext;
  logic signed [ACC_W-1:0]   comb_s;
  logic [ACC_W-1:0]          comb_m;
  logic [RMW-1:0]            trial;
  logic                      qbit;
  logic [DW:0]               qres;
  logic [AREA_W-1:0]         area_eff;

  always_comb begin
    case (cmd.op)
      OP_RHO_U: begin opa = OW'(signed'({1'b0, rho})); opb = pu;  end
      OP_RHO_V: begin opa = OW'(signed'({1'b0, rho})); opb = pv;  end
      OP_RUU:   begin opa = m0; opb = pu;  end
      OP_RVV:   begin opa = m1; opb = pv;  end
      OP_RUV:   begin opa = m0; opb = pv;  end
      OP_F_XUU: begin opa = nx; opb = ruu; end
      OP_F_YVV: begin opa = ny; opb = rvv; end
      OP_F_XUV: begin opa = nx; opb = ruv; end
      OP_F_YUV: begin opa = ny; opb = ruv; end
      OP_A_XXX: begin opa = nx; opb = sxx; end
      OP_A_YYY: begin opa = ny; opb = syy; end
      OP_A_XXY: begin opa = nx; opb = sxy; end
      OP_A_YXY: begin opa = ny; opb = sxy; end
      default:  begin opa = '0; opb = '0;  end
    endcase
    ma = opa[OW-1] ? OW'(-opa) : OW'(opa);
    mb = opb[OW-1] ? OW'(-opb) : OW'(opb);
  end

  assign pres = from_mag(WW'(prod >> FRAC_BITS), psign);
  assign pext = ACC_W'(signed'(pres[DW-1:0]));

  always_comb begin
    if (!cmd.axis)
      comb_s = ssub(sadd(asum[0], asum[3]), sadd(fsum[0], fsum[3]));
    else
      comb_s = ssub(sadd(asum[2], asum[1]), sadd(fsum[2], fsum[1]));
    comb_m = comb_s[ACC_W-1] ? -comb_s : comb_s;
  end

  assign area_eff = (area == '0) ? AREA_W'(1) : area;
  assign trial    = {rem, num[NW-1]};
  assign qbit     = (trial >= {1'b0, dreg});
  assign qres     = from_mag(WW'(num), dneg);

  assign sts.last     = last;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rho       <= RHO_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        fsum[i] <= '0;
        asum[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        rho <= cfg_wdata;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.wb) begin
        case (cmd.op)
          OP_F_XUU: fsum[0] <= sadd(fsum[0], pext);
          OP_F_YVV: fsum[1] <= sadd(fsum[1], pext);
          OP_F_XUV: fsum[2] <= sadd(fsum[2], pext);
          OP_F_YUV: fsum[3] <= sadd(fsum[3], pext);
          OP_A_XXX: asum[0] <= sadd(asum[0], pext);
          OP_A_YYY: asum[1] <= sadd(asum[1], pext);
          OP_A_XXY: asum[2] <= sadd(asum[2], pext);
          OP_A_YXY: asum[3] <= sadd(asum[3], pext);
          default: begin
          end
        endcase
      end
      if (cmd.out_load) begin
        for (int i = 0; i < 4; i++) begin
          fsum[i] <= '0;
          asum[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nx   <= OW'(normal_x);
      ny   <= OW'(normal_y);
      sxx  <= OW'(avg_stress_xx);
      sxy  <= OW'(avg_stress_xy);
      syy  <= OW'(avg_stress_yy);
      pu   <= sat_diff(DFW'(inst_u) - DFW'(avg_u));
      pv   <= sat_diff(DFW'(inst_v) - DFW'(avg_v));
      area <= cell_area;
      last <= last_node;
    end
    if (cmd.issue) begin
      prod  <= PW'(ma) * PW'(mb);
      psign <= opa[OW-1] ^ opb[OW-1];
    end
    if (cmd.wb) begin
      case (cmd.op)
        OP_RHO_U: m0  <= OW'(signed'(pres[DW-1:0]));
        OP_RHO_V: m1  <= OW'(signed'(pres[DW-1:0]));
        OP_RUU:   ruu <= OW'(signed'(pres[DW-1:0]));
        OP_RVV:   rvv <= OW'(signed'(pres[DW-1:0]));
        OP_RUV:   ruv <= OW'(signed'(pres[DW-1:0]));
        default: begin
        end
      endcase
    end
    if (cmd.div_ld) begin
      num  <= {comb_m, {FRAC_BITS{1'b0}}};
      dneg <= comb_s[ACC_W-1];
      rem  <= '0;
      dreg <= {area_eff, 1'b0};
    end
    if (cmd.div_step) begin
      num <= {num[NW-2:0], qbit};
      rem <= qbit ? (RMW-1)'(trial - {1'b0, dreg}) : trial[RMW-2:0];
    end
    if (cmd.div_fin) begin
      if (!cmd.axis) begin
        res_x  <= qres[DW-1:0];
        clip_x <= qres[DW];
      end else begin
        res_y  <= qres[DW-1:0];
        clip_y <= qres[DW];
      end
    end
    if (cmd.out_load) begin
      source_x  <= res_x;
      source_y  <= res_y;
      saturated <= clip_x | clip_y;
    end
  end

endmodule
`default_nettype wire

// ----- design/reynolds_stress_source_per_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reynolds_stress_source_per_cell
// Accumulates the Reynolds stress momentum source of one mesh cell, one node
// per input transfer, and delivers the two source terms after the last node.
//
// The input channel takes one node per transfer; last_node marks the final
// node of a cell. A node occupies the shared multiplier for 13 products, and
// the next node is accepted only after they are done.
// On the last node the x and y terms go through the bit-serial divider in
// turn, each with a load, a run and a finish step; the next node is accepted
// once both results have moved to the output register.
// The result sits in an output register; while it waits for the receiver the
// block keeps accepting nodes of the next cell, and it stalls only when a
// second result is ready before the first was taken.
// The user must write mean_density through cfg_we and cfg_wdata only while
// the block is idle; the block does not enforce this. Reset sets mean_density
// to 1.0 at the default FRAC_BITS, clears the sums and drops out_valid.
// ----------------------------------------------------------------------------
module reynolds_stress_source_per_cell
  import rss_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [RHO_W-1:0]        cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [IN_W-1:0]  normal_x,
  input  wire logic signed [IN_W-1:0]  normal_y,
  input  wire logic signed [IN_W-1:0]  inst_u,
  input  wire logic signed [IN_W-1:0]  inst_v,
  input  wire logic signed [IN_W-1:0]  avg_u,
  input  wire logic signed [IN_W-1:0]  avg_v,
  input  wire logic signed [IN_W-1:0]  avg_stress_xx,
  input  wire logic signed [IN_W-1:0]  avg_stress_xy,
  input  wire logic signed [IN_W-1:0]  avg_stress_yy,
  input  wire logic [AREA_W-1:0]       cell_area,
  input  wire logic                    last_node,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [DATA_WIDTH-1:0] source_x,
  output logic signed [DATA_WIDTH-1:0] source_y,
  output logic                         saturated
);

  rss_cmd_t cmd;
  rss_sts_t sts;

  rss_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rss_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .inst_u        (inst_u),
    .inst_v        (inst_v),
    .avg_u         (avg_u),
    .avg_v         (avg_v),
    .avg_stress_xx (avg_stress_xx),
    .avg_stress_xy (avg_stress_xy),
    .avg_stress_yy (avg_stress_yy),
    .cell_area     (cell_area),
    .last_node     (last_node),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .source_x      (source_x),
    .source_y      (source_y),
    .saturated     (saturated)
  );

endmodule
`default_nettype wire
